### rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and round functions for the sha-1 digest core
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    // command from front to back: one byte to place or a finish
    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } cmd_t;

    function automatic logic [31:0] rotl5(input logic [31:0] v);
        rotl5 = {v[26:0], v[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] v);
        rotl30 = {v[1:0], v[31:2]};
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] r);
        if (r < 7'd20)      round_k = K0;
        else if (r < 7'd40) round_k = K1;
        else if (r < 7'd60) round_k = K2;
        else                round_k = K3;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (r < 7'd20)
            round_f = (b & c) | (~b & d);
        else if (r >= 7'd40 && r < 7'd60)
            round_f = (b & c) | (b & d) | (c & d);
        else
            round_f = b ^ c ^ d;
    endfunction

endpackage

### rtl/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// streaming sha-1 digest: byte transactions in, five digest words out
// ----------------------------------------------------------------------------
// input channel: push/full; action 0 absorbs data_byte, action 1 finishes
// the message. a four-entry command queue parts the input from the engine.
// output channel: empty/pop; after a finish the five words h0..h4 appear in
// order with word_index and last_word on the fifth.
// bytes are absorbed in the idle state; every 64th byte starts a compression
// (load, 80 rounds one per cycle, chain add) during which no byte is taken,
// so throughput is set by the single round unit.
// a finish takes the remaining pad bytes one per cycle plus one or two
// compressions before the first word shows.
// reset restores the initial chaining words and clears the bit count.
// while the receiver stalls the engine holds its words and the queue fills
// until full rises.
// ----------------------------------------------------------------------------
module sha1_message_digest_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    logic cmd_valid, cmd_take;
    cmd_t cmd;

    sha1_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .action(action),
        .data_byte(data_byte), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    sha1_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .empty(empty), .pop(pop), .digest_word(digest_word),
        .word_index(word_index), .last_word(last_word)
    );

endmodule

### rtl/sha1_front.sv
// ----------------------------------------------------------------------------
// sha1_front
// input side: accepts transactions and queues them as commands
// ----------------------------------------------------------------------------
module sha1_front
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       action,
    input  logic [7:0] data_byte,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    cmd_t             q_mem [CMDQ_DEPTH];
    logic [CMDQ_AW:0] wr_ptr_reg, rd_ptr_reg;
    logic             accept;

    assign full      = (wr_ptr_reg[CMDQ_AW] != rd_ptr_reg[CMDQ_AW]) &&
                       (wr_ptr_reg[CMDQ_AW-1:0] == rd_ptr_reg[CMDQ_AW-1:0]);
    assign cmd_valid = (wr_ptr_reg != rd_ptr_reg);
    assign accept    = push && !full;
    assign cmd       = q_mem[rd_ptr_reg[CMDQ_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg[CMDQ_AW-1:0]] <= '{fin: action, data: data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (cmd_take && cmd_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

### rtl/sha1_back.sv
// ----------------------------------------------------------------------------
// sha1_back
// execution side: block fill, padding, 80-round compression, digest output
// ----------------------------------------------------------------------------
module sha1_back
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg;
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] w_reg [16];
    logic [63:0] bit_count_reg, len_reg;
    logic [5:0]  pos_reg;
    logic [6:0]  round_reg;
    logic        fin_reg;       // finishing: pad block in progress
    logic        len_done_reg;  // length already placed in current block
    logic [2:0]  out_idx_reg;

    logic [31:0] w_mix, w_new, w_cur, t_sum;
    logic [3:0]  slot;
    logic [7:0]  pad_byte;

    assign slot  = round_reg[3:0];
    assign w_mix = w_reg[slot + 4'd13] ^ w_reg[slot + 4'd8] ^ w_reg[slot + 4'd2]
                   ^ w_reg[slot];
    assign w_new = {w_mix[30:0], w_mix[31]};
    assign w_cur = (round_reg < 7'd16) ? w_reg[slot] : w_new;
    assign t_sum = rotl5(a_reg) + round_f(round_reg, b_reg, c_reg, d_reg) + e_reg
                   + round_k(round_reg) + w_cur;

    // padding byte at current position
    always_comb
    begin
        pad_byte = 8'h00;
        if (len_done_reg && pos_reg >= 6'd56)
            pad_byte = len_reg[{~pos_reg[2:0], 3'b111} -: 8];
    end

    assign cmd_take    = cmd_valid && (state_reg == S_IDLE);
    assign empty       = (state_reg != S_OUT);
    assign digest_word = h_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd4);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && !cmd.fin)
            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], cmd.data};
        else if (state_reg == S_IDLE && cmd_valid && cmd.fin)
            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], PAD_BYTE};
        else if (state_reg == S_PAD)
            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], pad_byte};
        else if (state_reg == S_ROUND && round_reg >= 7'd16)
            w_reg[slot] <= w_new;
        if (state_reg == S_IDLE && cmd_valid && cmd.fin)
            len_reg <= bit_count_reg;
        if (state_reg == S_LOAD)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (state_reg == S_ROUND)
        begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg[0]      <= H0_INIT;
            h_reg[1]      <= H1_INIT;
            h_reg[2]      <= H2_INIT;
            h_reg[3]      <= H3_INIT;
            h_reg[4]      <= H4_INIT;
            bit_count_reg <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            fin_reg       <= 1'b0;
            len_done_reg  <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        pos_reg <= pos_reg + 6'd1;
                        if (!cmd.fin)
                        begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                            if (pos_reg == 6'd63)
                                state_reg <= S_LOAD;
                        end
                        else
                        begin
                            fin_reg      <= 1'b1;
                            len_done_reg <= (pos_reg < 6'd56);
                            state_reg    <= (pos_reg == 6'd63) ? S_LOAD : S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd63)
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    round_reg <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (round_reg == LAST_ROUND)
                    begin
                        round_reg <= '0;
                        state_reg <= S_ADD;
                    end
                    else
                        round_reg <= round_reg + 7'd1;
                end
                S_ADD:
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    if (!fin_reg)
                        state_reg <= S_IDLE;
                    else if (len_done_reg)
                    begin
                        out_idx_reg <= '0;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        // length did not fit: one extra all-zero block
                        len_done_reg <= 1'b1;
                        state_reg    <= S_PAD;
                    end
                end
                S_OUT:
                begin
                    if (pop)
                    begin
                        if (out_idx_reg == 3'd4)
                        begin
                            h_reg[0]      <= H0_INIT;
                            h_reg[1]      <= H1_INIT;
                            h_reg[2]      <= H2_INIT;
                            h_reg[3]      <= H3_INIT;
                            h_reg[4]      <= H4_INIT;
                            bit_count_reg <= '0;
                            pos_reg       <= '0;
                            fin_reg       <= 1'b0;
                            len_done_reg  <= 1'b0;
                            out_idx_reg   <= '0;
                            state_reg     <= S_IDLE;
                        end
                        else
                            out_idx_reg <= out_idx_reg + 3'd1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks on the digest core
// ----------------------------------------------------------------------------
module sha1_checker
    import sha1_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (word_index <= 3'd4))
        else $error("word_index out of range");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_word == (word_index == 3'd4)))
        else $error("last_word mismatch");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_word) |=> (!empty && word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_index)))
        else $error("stalled word changed");

endmodule

bind sha1_message_digest_core sha1_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
);
